// File: hw/rtl/rqsr_pkg.sv
`timescale 1ns / 1ps
// shared constants, command codes and types of the ring queue with swap-remove
// no dependencies

package rqsr_pkg;

  localparam int DEPTH   = 128;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int ITEM_W  = 32;
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

  typedef struct packed {
    logic [ITEM_W-1:0]  item;
    logic               valid;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [ITEM_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

endpackage

// File: hw/rtl/rqsr_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module rqsr_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rqsr_ctrl.sv
`timescale 1ns / 1ps
// command sequencer: head and fill registers, slot reads, swap write-back
// depends on rqsr_pkg

module rqsr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rqsr_pkg::CMD_W-1:0]   in_cmd,
  input  logic [rqsr_pkg::INDEX_W-1:0] in_index,
  input  logic [rqsr_pkg::ITEM_W-1:0]  in_value,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rqsr_pkg::res_t              res,
  output rqsr_pkg::mem_req_t          mem_req,
  input  logic [rqsr_pkg::ITEM_W-1:0]  mem_rdata
);

  import rqsr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DATA  = 3'd1;
  localparam logic [2:0] S_SWAP  = 3'd2;
  localparam logic [2:0] S_WBACK = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  logic [2:0]        state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic              swap, swap_next;
  logic [PTR_W-1:0]  addr_a, addr_a_next;
  logic [PTR_W-1:0]  addr_b, addr_b_next;
  logic [ITEM_W-1:0] item, item_next;
  res_t              res_next;

  logic [PTR_W-1:0]  at_index;
  logic [PTR_W-1:0]  at_last;
  logic [PTR_W-1:0]  at_tail;
  logic [CNT_W-1:0]  fill_dec;
  logic              empty;

  assign at_index = head + PTR_W'(in_index);
  assign fill_dec = fill - CNT_W'(1);
  assign at_last  = head + fill_dec[PTR_W-1:0];
  assign at_tail  = head + fill[PTR_W-1:0];
  assign empty    = (fill == '0);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RES);

  always_comb begin
    state_next  = state;
    head_next   = head;
    fill_next   = fill;
    swap_next   = swap;
    addr_a_next = addr_a;
    addr_b_next = addr_b;
    item_next   = item;
    res_next    = res;
    mem_req     = '0;
    mem_req.raddr = addr_a;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          swap_next  = 1'b0;
          state_next = S_RES;
          res_next   = '{item: '0, valid: 1'b0, count: COUNT_W'(fill)};
          case (in_cmd)
            CMD_PUSH: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = at_tail;
              mem_req.wdata = in_value;
              if (fill == CNT_W'(DEPTH)) begin
                head_next = head + PTR_W'(1);
              end else begin
                fill_next      = fill + CNT_W'(1);
                res_next.count = COUNT_W'(fill + CNT_W'(1));
              end
            end
            CMD_GET: begin
              if (!empty) begin
                mem_req.raddr = at_index;
                state_next    = S_DATA;
              end
            end
            CMD_REMOVE: begin
              if (fill >= CNT_W'(2)) begin
                mem_req.raddr = at_index;
                addr_a_next   = at_index;
                addr_b_next   = at_last;
                fill_next     = fill_dec;
                swap_next     = 1'b1;
                state_next    = S_DATA;
              end else if (!empty) begin
                mem_req.raddr = head;
                fill_next     = '0;
                head_next     = '0;
                state_next    = S_DATA;
              end
            end
            CMD_POP_FRONT: begin
              if (!empty) begin
                mem_req.raddr = head;
                fill_next     = fill_dec;
                head_next     = (fill_dec == '0) ? '0 : head + PTR_W'(1);
                state_next    = S_DATA;
              end
            end
            CMD_POP_BACK: begin
              if (!empty) begin
                mem_req.raddr = at_last;
                fill_next     = fill_dec;
                if (fill_dec == '0) begin
                  head_next = '0;
                end
                state_next = S_DATA;
              end
            end
            CMD_CLEAR: begin
              head_next      = '0;
              fill_next      = '0;
              res_next.count = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        if (swap) begin
          item_next     = mem_rdata;
          mem_req.raddr = addr_b;
          state_next    = S_SWAP;
        end else begin
          res_next   = '{item: mem_rdata, valid: 1'b1, count: COUNT_W'(fill)};
          state_next = S_RES;
        end
      end
      S_SWAP: begin
        // last entry moves into the addressed slot
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_a;
        mem_req.wdata = mem_rdata;
        state_next    = S_WBACK;
      end
      S_WBACK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_b;
        mem_req.wdata = item;
        res_next      = '{item: item, valid: 1'b1, count: COUNT_W'(fill)};
        state_next    = S_RES;
      end
      S_RES: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      fill  <= '0;
      swap  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      swap  <= swap_next;
    end
  end

  always_ff @(posedge clk) begin
    addr_a <= addr_a_next;
    addr_b <= addr_b_next;
    item   <= item_next;
    res    <= res_next;
  end

endmodule

// File: hw/rtl/ring_queue_swap_remove.sv
`timescale 1ns / 1ps
// top level of the ring queue with swap-remove: stream ports, output register
// depends on rqsr_pkg, rqsr_ram, rqsr_ctrl
//
//   channel  | dir | tdata                                   | tuser
//   s_axis   | in  | [6:0] index, [38:7] item_value          | [2:0] cmd
//   m_axis   | out | [31:0] item_out, [39:32] count_after    | [0] item_valid
//
// push, clear, unused codes and misses on an empty queue go straight to the result
// state; get and pops pass the data state, and remove with two or more entries also
// the swap and write-back states: the swap needs two slot reads and two write-backs
// through the single read and write port. the result sits in an output register, so
// a stalled m side holds one finished transfer while the next command is already
// taken. rst is synchronous and empties the queue; slot contents are not cleared.

module ring_queue_swap_remove (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // index, item_value
  input  logic [2:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // item_out, count_after
  output logic        m_tuser    // item_valid
);

  import rqsr_pkg::*;

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  mem_req_t           mem_req;
  logic [ITEM_W-1:0]  mem_rdata;

  rqsr_ram #(
    .DATA_W(ITEM_W),
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  rqsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser[CMD_W-1:0]),
    .in_index (s_tdata[INDEX_W-1:0]),
    .in_value (s_tdata[INDEX_W+ITEM_W-1:INDEX_W]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {res.count, res.item};
      m_tuser <= res.valid;
    end
  end

endmodule
